>>> design/psb_pkg.sv
// shared types and codes of the positional sequence buffer
`default_nettype none

package psb_pkg;

  // request kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_UP,
    S_PUT,
    S_DOWN,
    S_DONE
  } state_e;

  // memory read address select
  typedef enum logic [2:0] {
    A_POS,
    A_CNT_M1,
    A_IDX_M2,
    A_IDX_P1,
    A_IDX_P2
  } addr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_CNT,
    IDX_LOAD_POS,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    W_NONE,
    W_RDATA,
    W_VAL
  } wr_sel_e;

  typedef struct packed {
    logic       cap;
    addr_sel_e  rd_sel;
    idx_op_e    idx_op;
    wr_sel_e    wr_sel;
    logic       set_status;
    logic [1:0] status_code;
    logic       load_got;
    logic       finish;
  } psb_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pos_bad;
    logic       full;
    logic       pos_at_end;
    logic       up_last;
    logic       got_last;
    logic       down_last;
    logic       out_free;
  } psb_stat_t;

endpackage

`default_nettype wire

>>> design/positional_sequence_buffer.sv
// top level of the positional sequence buffer
`default_nettype none

// Ordered byte store of up to CAPACITY entries with read, insert and remove at a
// position; each request gives one result with the byte, a status and the new length.
// One request is handled at a time. An insert shifts the entries at and above the
// position up, a remove those above it down, one entry per cycle through the single
// read port and single write port of the entry memory. A finished result waits in the
// output register while the next request is taken. The entry memory is not cleared
// after reset: only written entries ever reach a result or stay in the sequence, so
// the block is ready as soon as reset is released.

module positional_sequence_buffer #(
  parameter int CAPACITY = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] position_i,
  input  wire logic [7:0] value_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      item_o,
  output logic [1:0]      status_o,
  output logic [7:0]      count_o
);

  import psb_pkg::*;

  psb_cmd_t  cmd;
  psb_stat_t stat;

  psb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (item_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

endmodule

`default_nettype wire

>>> design/psb_ram.sv
// generic single write port ram with registered read
`default_nettype none

module psb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/psb_ctrl.sv
// controller state machine of the positional sequence buffer
`default_nettype none

module psb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire psb_pkg::psb_stat_t  stat_i,
  output psb_pkg::psb_cmd_t        cmd_o
);

  import psb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat_i.kind)
          KIND_READ, KIND_REMOVE: begin
            state_d = stat_i.pos_bad ? S_DONE : S_FETCH;
          end
          KIND_INSERT: begin
            if (stat_i.pos_bad || stat_i.full) state_d = S_DONE;
            else if (stat_i.pos_at_end)        state_d = S_PUT;
            else                               state_d = S_UP;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_FETCH: begin
        if (stat_i.kind == KIND_READ || stat_i.got_last) state_d = S_DONE;
        else                                             state_d = S_DOWN;
      end
      S_UP: begin
        if (stat_i.up_last) state_d = S_PUT;
      end
      S_PUT: state_d = S_DONE;
      S_DOWN: begin
        if (stat_i.down_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.rd_sel      = A_POS;
    cmd_o.idx_op      = IDX_HOLD;
    cmd_o.wr_sel      = W_NONE;
    cmd_o.status_code = ST_OK;
    in_stall_o        = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.cap = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.set_status = 1'b1;
        unique case (stat_i.kind)
          KIND_READ: begin
            if (stat_i.pos_bad) cmd_o.status_code = ST_BADPOS;
          end
          KIND_REMOVE: begin
            if (stat_i.pos_bad) cmd_o.status_code = ST_BADPOS;
            else                cmd_o.idx_op      = IDX_LOAD_POS;
          end
          KIND_INSERT: begin
            if (stat_i.pos_bad)   cmd_o.status_code = ST_BADPOS;
            else if (stat_i.full) cmd_o.status_code = ST_FULL;
            else begin
              cmd_o.rd_sel = A_CNT_M1;
              cmd_o.idx_op = IDX_LOAD_CNT;
            end
          end
          default: ;
        endcase
      end
      S_FETCH: begin
        cmd_o.load_got = 1'b1;
        cmd_o.rd_sel   = A_IDX_P1;
      end
      S_UP: begin
        cmd_o.wr_sel = W_RDATA;
        cmd_o.rd_sel = A_IDX_M2;
        cmd_o.idx_op = IDX_DEC;
      end
      S_PUT: begin
        cmd_o.wr_sel = W_VAL;
      end
      S_DOWN: begin
        cmd_o.wr_sel = W_RDATA;
        cmd_o.rd_sel = A_IDX_P2;
        cmd_o.idx_op = IDX_INC;
      end
      S_DONE: begin
        cmd_o.finish = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/psb_dp.sv
// datapath: request registers, entry memory, shift index, length and result register
`default_nettype none

module psb_dp #(
  parameter int CAPACITY = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire psb_pkg::psb_cmd_t  cmd_i,
  output psb_pkg::psb_stat_t      stat_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [7:0]         position_i,
  input  wire logic [7:0]         value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              item_o,
  output logic [1:0]              status_o,
  output logic [7:0]              count_o
);

  import psb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // compare width: covers the position field and the length, plus headroom for +2
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  logic [1:0]    kind_q;
  logic [7:0]    pos_q;
  logic [7:0]    val_q;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [7:0]    got_q;
  logic [1:0]    st_q;
  logic          out_valid_q;
  logic [7:0]    item_q;
  logic [1:0]    status_q;

  logic [XW-1:0] pos_x, fill_x, idx_x;
  logic [AW-1:0] pos_a, raddr, waddr;
  logic [7:0]    rdata, wdata;
  logic          we;

  assign pos_x  = XW'(pos_q);
  assign fill_x = XW'(fill_q);
  assign idx_x  = XW'(idx_q);
  assign pos_a  = pos_x[AW-1:0];

  // status towards the controller
  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.pos_bad    = (kind_q == KIND_INSERT) ? (pos_x > fill_x) : (pos_x >= fill_x);
    stat_o.full       = (fill_q == CW'(CAPACITY));
    stat_o.pos_at_end = (pos_x == fill_x);
    stat_o.up_last    = (idx_x == pos_x + XW'(1));
    stat_o.got_last   = (pos_x + XW'(1) == fill_x);
    stat_o.down_last  = (idx_x + XW'(2) == fill_x);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // memory addressing
  always_comb begin
    logic [XW-1:0] a;
    a = pos_x;
    unique case (cmd_i.rd_sel)
      A_POS:    a = pos_x;
      A_CNT_M1: a = fill_x - XW'(1);
      A_IDX_M2: a = idx_x - XW'(2);
      A_IDX_P1: a = idx_x + XW'(1);
      A_IDX_P2: a = idx_x + XW'(2);
      default:  a = pos_x;
    endcase
    raddr = a[AW-1:0];
  end

  assign we    = (cmd_i.wr_sel != W_NONE);
  assign waddr = (cmd_i.wr_sel == W_VAL) ? pos_a : idx_q;
  assign wdata = (cmd_i.wr_sel == W_VAL) ? val_q : rdata;

  psb_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    logic [XW-1:0] cm1;
    cm1   = fill_x - XW'(1);
    idx_d = idx_q;
    unique case (cmd_i.idx_op)
      IDX_HOLD:     idx_d = idx_q;
      IDX_LOAD_CNT: idx_d = fill_x[AW-1:0];
      IDX_LOAD_POS: idx_d = pos_a;
      IDX_DEC:      idx_d = idx_q - AW'(1);
      IDX_INC:      idx_d = idx_q + AW'(1);
      default:      idx_d = cm1[AW-1:0];
    endcase
  end

  // length moves only when a successful insert or remove completes
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.finish && st_q == ST_OK) begin
      if (kind_q == KIND_INSERT)      fill_d = fill_q + CW'(1);
      else if (kind_q == KIND_REMOVE) fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.finish)      out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    idx_q <= idx_d;
    if (cmd_i.set_status) st_q  <= cmd_i.status_code;
    if (cmd_i.load_got)   got_q <= rdata;
    if (cmd_i.finish) begin
      status_q <= st_q;
      item_q   <= (st_q == ST_OK && (kind_q == KIND_READ || kind_q == KIND_REMOVE))
                  ? got_q : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_o      = item_q;
  assign status_o    = status_q;
  assign count_o     = fill_x[7:0];

endmodule

`default_nettype wire

>>> test/psb_checker.sv
// checker for the positional sequence buffer: tracks the sequence, predicts and compares results
`timescale 1ns / 100ps

module psb_checker #(
  parameter int CAPACITY = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] position_i,
  input  wire logic [7:0] value_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] item_i,
  input  wire logic [1:0] status_i,
  input  wire logic [7:0] count_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              seq_len_o,
  output int              full_seen_o,
  output int              badpos_seen_o
);

  import psb_pkg::*;

  typedef struct packed {
    logic [7:0] item;
    logic [1:0] status;
    logic [7:0] count;
  } psb_result_t;

  logic [7:0]  seq_bytes [CAPACITY];
  int unsigned seq_count = 0;
  psb_result_t due_results [$];

  int fails = 0;
  int full_hits = 0;
  int badpos_hits = 0;
  int outstanding = 0;

  assign fail_count_o  = fails;
  assign pending_o     = outstanding;
  assign seq_len_o     = seq_count;
  assign full_seen_o   = full_hits;
  assign badpos_seen_o = badpos_hits;

  // applies one request to the tracked sequence and returns the result it should give
  task automatic apply_request(input logic [1:0] kind, input logic [7:0] pos,
                               input logic [7:0] val, output psb_result_t res);
    int unsigned i;
    res.item   = 8'd0;
    res.status = ST_OK;
    case (kind)
      KIND_READ: begin
        if (pos >= seq_count) res.status = ST_BADPOS;
        else res.item = seq_bytes[pos];
      end
      KIND_INSERT: begin
        if (pos > seq_count) begin
          res.status = ST_BADPOS;
        end else if (seq_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = seq_count; i > pos; i--) seq_bytes[i] = seq_bytes[i - 1];
          seq_bytes[pos] = val;
          seq_count++;
        end
      end
      KIND_REMOVE: begin
        if (pos >= seq_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.item = seq_bytes[pos];
          for (i = pos; i + 1 < seq_count; i++) seq_bytes[i] = seq_bytes[i + 1];
          seq_count--;
        end
      end
      default: ;
    endcase
    res.count = seq_count[7:0];
  endtask

  always @(posedge clk_i) begin
    psb_result_t want;
    psb_result_t fresh;
    if (rst_ni) begin
      // a result always belongs to an earlier transfer, so retire before predicting
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: item %0d status %0d count %0d",
                 item_i, status_i, count_i);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (item_i !== want.item) begin
            $error("item mismatch: expected %0d, actual %0d", want.item, item_i);
            fails++;
          end
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_i);
            fails++;
          end
          if (count_i !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, count_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(kind_i, position_i, value_i, fresh);
        if (fresh.status == ST_FULL) full_hits++;
        if (fresh.status == ST_BADPOS) badpos_hits++;
        due_results.push_back(fresh);
      end
      outstanding = due_results.size();
    end
  end

endmodule

>>> test/tb_top.sv
// testbench top of the positional sequence buffer: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
  import psb_pkg::*;

  localparam int CAPACITY = 128;
  localparam int RANDOM_ITEMS = 1230;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i = KIND_READ;
  logic [7:0] position_i = 8'd0;
  logic [7:0] value_i = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] item_o;
  logic [1:0] status_o;
  logic [7:0] count_o;

  int fail_count;
  int pending;
  int seq_len;
  int full_seen;
  int badpos_seen;

  int tx_idle_pct = 35;
  int rx_idle_pct = 63;
  int sent = 0;
  int peak_len = 0;
  bit growing = 1'b1;

  positional_sequence_buffer #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .position_i (position_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .item_o     (item_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  psb_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .item_i       (item_o),
    .status_i     (status_o),
    .count_i      (count_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .seq_len_o    (seq_len),
    .full_seen_o  (full_seen),
    .badpos_seen_o(badpos_seen)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer_request(input logic [1:0] kind, input logic [7:0] pos,
                               input logic [7:0] val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent++;
    if (seq_len > peak_len) peak_len = seq_len;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly well-formed requests, drifting between filling up to full and draining to empty
  task automatic pick_request(output logic [1:0] kind, output logic [7:0] pos,
                              output logic [7:0] val);
    int len;
    int r;
    int hi;
    int s;
    len = seq_len;
    r   = $urandom_range(0, 99);
    val = 8'($urandom_range(0, 255));
    if (growing && len == CAPACITY && $urandom_range(0, 99) < 15) growing = 1'b0;
    else if (!growing && len == 0 && $urandom_range(0, 99) < 40) growing = 1'b1;
    else if ($urandom_range(0, 99) == 0) growing = !growing;

    if (r >= 90) begin
      // noise: unused kind or a position beyond the end
      if ($urandom_range(0, 1) == 0) begin
        kind = KIND_UNUSED;
        pos  = 8'($urandom_range(0, 255));
      end else begin
        case ($urandom_range(0, 2))
          0:       kind = KIND_READ;
          1:       kind = KIND_INSERT;
          default: kind = KIND_REMOVE;
        endcase
        pos = 8'($urandom_range((kind == KIND_INSERT) ? len + 1 : len, 255));
      end
    end else begin
      if (r < 55) kind = growing ? KIND_INSERT : KIND_REMOVE;
      else if (r < 75) kind = KIND_READ;
      else kind = growing ? KIND_REMOVE : KIND_INSERT;
      hi = (kind == KIND_INSERT) ? len : len - 1;
      s  = $urandom_range(0, 3);
      if (hi < 0) pos = 8'($urandom_range(0, 3));
      else if (s == 0) pos = 8'd0;
      else if (s == 1) pos = 8'(hi);
      else pos = 8'($urandom_range(0, hi));
    end
  endtask

  initial begin
    logic [1:0] kind;
    logic [7:0] pos;
    logic [7:0] val;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty store, both ends, middle, unused kind and out-of-range positions
    offer_request(KIND_READ,   8'd0,   8'h00);
    offer_request(KIND_REMOVE, 8'd0,   8'h00);
    offer_request(KIND_INSERT, 8'd1,   8'h11);
    offer_request(KIND_INSERT, 8'd0,   8'h00);
    offer_request(KIND_INSERT, 8'd1,   8'hff);
    offer_request(KIND_INSERT, 8'd0,   8'h5a);
    offer_request(KIND_INSERT, 8'd1,   8'ha5);
    offer_request(KIND_UNUSED, 8'd255, 8'hff);
    offer_request(KIND_READ,   8'd0,   8'h00);
    offer_request(KIND_READ,   8'd3,   8'h00);
    offer_request(KIND_READ,   8'd4,   8'h00);
    offer_request(KIND_READ,   8'd255, 8'hff);
    offer_request(KIND_INSERT, 8'd5,   8'h77);
    offer_request(KIND_INSERT, 8'd255, 8'h88);
    offer_request(KIND_REMOVE, 8'd1,   8'h00);
    offer_request(KIND_REMOVE, 8'd2,   8'h00);
    offer_request(KIND_REMOVE, 8'd0,   8'h00);
    offer_request(KIND_REMOVE, 8'd128, 8'h00);
    offer_request(KIND_READ,   8'd0,   8'h00);
    offer_request(KIND_UNUSED, 8'd0,   8'h00);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        wait_drained();
        tx_idle_pct = 63;
        rx_idle_pct = 35;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick_request(kind, pos, val);
      offer_request(kind, pos, val);
    end

    wait_drained();
    // keep the clock running to catch any stray result
    repeat (140) @(negedge clk_i);

    $display("tb: %0d requests sent, peak length %0d of %0d", sent, peak_len, CAPACITY);
    $display("tb: %0d inserts refused as full, %0d bad positions flagged",
             full_seen, badpos_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
